>>> rtl/core/hecl_pkg.sv
// ----------------------------------------------------------------------------
// hecl_pkg
// Types, codes and the per-point judgement shared by the hole edge labeler
// ----------------------------------------------------------------------------
package hecl_pkg;

  typedef enum logic [1:0] {
    MODE_SCAN   = 2'd0,
    MODE_INSIDE = 2'd1
  } mode_t;

  typedef enum logic [1:0] {
    LABEL_NONE   = 2'd0,
    LABEL_EDGE   = 2'd1,
    LABEL_INSIDE = 2'd2
  } label_t;

  typedef enum logic [2:0] {
    REG_GROUND_LEVEL = 3'd0,
    REG_START_DROP   = 3'd1,
    REG_CLOSE_BAND   = 3'd2,
    REG_START_LIMIT  = 3'd3,
    REG_SEARCH_LIMIT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] ground_level;
    logic [14:0]        start_drop;
    logic [14:0]        close_band;
    logic [5:0]         start_limit;
    logic [5:0]         search_limit;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [6:0]         resume_index;
    logic signed [15:0] hole_start;
  } hole_state_t;

  typedef struct packed {
    label_t      label;
    hole_state_t st;
  } judge_t;

  typedef struct packed {
    label_t     label;
    logic [5:0] beam_index;
    logic       last;
  } result_t;

  // label one point and advance the hole state
  function automatic judge_t judge(hole_state_t st, cfg_t cfg, logic signed [15:0] h,
                                   logic inv, logic [5:0] idx, logic has_next,
                                   logic signed [15:0] next_h);
    logic signed [16:0] drop;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [6:0]         idx_inc;
    logic               opens;
    judge_t             r;
    drop    = $signed({h[15], h}) - $signed({next_h[15], next_h});
    diff    = $signed({h[15], h}) - $signed({st.hole_start[15], st.hole_start});
    mag     = diff[16] ? 17'(-diff) : 17'(diff);
    idx_inc = {1'b0, idx} + 7'd1;
    opens   = has_next && !inv && ({1'b0, idx} >= st.resume_index) &&
              (idx < cfg.start_limit) && (h <= cfg.ground_level) &&
              (drop > $signed({2'b00, cfg.start_drop}));
    r.st    = st;
    r.label = LABEL_NONE;
    if (st.mode == MODE_SCAN) begin
      if (opens) begin
        r.st.hole_start = h;
        r.label         = LABEL_EDGE;
        if (idx_inc >= {1'b0, cfg.search_limit}) begin
          r.st.resume_index = {1'b0, idx} + 7'd2;
        end else begin
          r.st.mode = MODE_INSIDE;
        end
      end
    end else if (idx >= cfg.search_limit) begin
      r.st.mode         = MODE_SCAN;
      r.st.resume_index = idx_inc;
    end else if (mag < {2'b00, cfg.close_band}) begin
      r.st.mode         = MODE_SCAN;
      r.st.resume_index = idx_inc;
      r.label           = LABEL_EDGE;
    end else begin
      r.label = LABEL_INSIDE;
      if (idx_inc >= {1'b0, cfg.search_limit}) begin
        r.st.mode         = MODE_SCAN;
        r.st.resume_index = {1'b0, cfg.search_limit} + 7'd1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/hole_edge_column_labeler_top.sv
// ----------------------------------------------------------------------------
// hole_edge_column_labeler_top
// Labels lidar points of one firing column as no mark, hole edge or inside hole
// ----------------------------------------------------------------------------
// Points enter one per transfer in beam order; each is judged when the next
// point arrives, so labels trail the input by one point, and the transfer that
// carries tlast releases two labels (the held point, then the last point).
// An input transfer is taken in every cycle while the four-entry result queue
// has room for two labels; the judgement of a point is done in the cycle of
// the transfer that brings the following point, and its label is registered
// into the queue and offered at its head. Sustained rate is one point per cycle
// without back-pressure, as n points yield n labels. Config writes act at once.
module hole_edge_column_labeler_top
  import hecl_pkg::*;
#(
  parameter int BEAMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // point stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] height_cm
  input  logic [0:0]  s_axis_tuser,   // [0] is_invalid
  input  logic        s_axis_tlast,   // column_end
  // label stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [1:0] label, [7:2] beam_index
  output logic        m_axis_tlast    // last_of_column
);

  // beam index saturates at the last beam, and never beyond a 6-bit index
  localparam logic [5:0] IDX_CAP = (BEAMS - 1 > 63) ? 6'd63 : 6'(BEAMS - 1);
  localparam int         QDEPTH  = 4;

  // configuration registers
  cfg_t cfg;

  // column state
  hole_state_t        hole;
  logic signed [15:0] held_height;
  logic               held_invalid;
  logic               held_present;
  logic [5:0]         beam_counter;

  // result queue, head in entry 0
  result_t    q [QDEPTH];
  logic [2:0] count;

  logic               in_xfer;
  logic               out_xfer;
  logic signed [15:0] in_height;
  judge_t             j_held;
  judge_t             j_last;
  logic [5:0]         idx;
  result_t            push0;
  result_t            push1;
  logic [1:0]         push_n;
  hole_state_t        hole_next;
  result_t            q_next [QDEPTH];
  logic [2:0]         base;
  logic [2:0]         count_next;

  assign in_height     = $signed(s_axis_tdata);
  assign s_axis_tready = (count <= 3'(QDEPTH - 2));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count != 3'd0);
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {q[0].beam_index, q[0].label};
  assign m_axis_tlast  = q[0].last;

  // judgement of the held point against the incoming one, then of the
  // incoming point itself when it closes the column
  always_comb begin
    j_held = judge(hole, cfg, held_height, held_invalid, beam_counter, 1'b1, in_height);
    if (held_present) begin
      idx = (beam_counter < IDX_CAP) ? beam_counter + 6'd1 : IDX_CAP;
    end else begin
      idx = 6'd0;
    end
    j_last = judge(held_present ? j_held.st : hole, cfg, in_height, s_axis_tuser[0],
                   idx, 1'b0, 16'sd0);

    push0.label      = j_held.label;
    push0.beam_index = beam_counter;
    push0.last       = 1'b0;
    push1.label      = j_last.label;
    push1.beam_index = idx;
    push1.last       = 1'b1;
    push_n           = 2'd0;
    hole_next        = held_present ? j_held.st : hole;

    if (held_present && s_axis_tlast) begin
      push_n = 2'd2;
    end else if (held_present) begin
      push_n = 2'd1;
    end else if (s_axis_tlast) begin
      push_n = 2'd1;
      push0  = push1;
    end

    if (s_axis_tlast) begin
      // column done: back to scanning, start height kept
      hole_next.mode         = MODE_SCAN;
      hole_next.resume_index = 7'd0;
      hole_next.hole_start   = j_last.st.hole_start;
    end
  end

  // queue update: shift out at the head, append up to two labels behind
  always_comb begin
    base       = count - {2'b00, out_xfer};
    count_next = base;
    if (in_xfer) begin
      count_next = base + {1'b0, push_n};
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (out_xfer && i < QDEPTH - 1) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (in_xfer && push_n != 2'd0 && 3'(i) == base) begin
        q_next[i] = push0;
      end
      if (in_xfer && push_n == 2'd2 && 3'(i) == base + 3'd1) begin
        q_next[i] = push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
    if (in_xfer) begin
      held_height     <= in_height;
      held_invalid    <= s_axis_tuser[0];
    end
    if (rst) begin
      count             <= 3'd0;
      hole.mode         <= MODE_SCAN;
      hole.resume_index <= 7'd0;
      hole.hole_start   <= 16'sd0;
      held_present      <= 1'b0;
      beam_counter      <= 6'd0;
      cfg.ground_level  <= -16'sd130;
      cfg.start_drop    <= 15'd5;
      cfg.close_band    <= 15'd5;
      cfg.start_limit   <= 6'd31;
      cfg.search_limit  <= 6'd32;
    end else begin
      count <= count_next;
      if (in_xfer) begin
        hole.mode         <= hole_next.mode;
        hole.resume_index <= hole_next.resume_index;
        hole.hole_start   <= hole_next.hole_start;
        held_present      <= !s_axis_tlast;
        beam_counter      <= s_axis_tlast ? 6'd0 : idx;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GROUND_LEVEL: cfg.ground_level <= $signed(cfg_data);
          REG_START_DROP:   cfg.start_drop   <= cfg_data[14:0];
          REG_CLOSE_BAND:   cfg.close_band   <= cfg_data[14:0];
          REG_START_LIMIT:  cfg.start_limit  <= cfg_data[5:0];
          REG_SEARCH_LIMIT: cfg.search_limit <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/core/hecl_checker.sv
// ----------------------------------------------------------------------------
// hecl_checker
// Port-level checks on the label stream of the hole edge labeler
// ----------------------------------------------------------------------------
module hecl_checker
  import hecl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  logic       out_xfer;
  logic       col_start;
  logic [5:0] prev_beam;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // track where the label stream stands within a column
  always_ff @(posedge clk) begin
    if (rst) begin
      col_start <= 1'b1;
      prev_beam <= 6'd0;
    end else if (out_xfer) begin
      col_start <= m_axis_tlast;
      prev_beam <= m_axis_tdata[7:2];
    end
  end

  // a stalled label holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast))
    else $error("label changed while stalled");

  a_label_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] == LABEL_NONE) ||
    (m_axis_tdata[1:0] == LABEL_EDGE) || (m_axis_tdata[1:0] == LABEL_INSIDE))
    else $error("label code out of range");

  a_col_first: assert property (@(posedge clk) disable iff (rst)
    out_xfer && col_start |-> m_axis_tdata[7:2] == 6'd0)
    else $error("first label of a column not at beam 0");

  a_beam_step: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !col_start |->
    (m_axis_tdata[7:2] == prev_beam + 6'd1) || (m_axis_tdata[7:2] == prev_beam))
    else $error("beam index skipped within a column");

endmodule

bind hole_edge_column_labeler_top hecl_checker u_hecl_checker (.*);
